/* hdl/lsbsd_pkg.sv */
// lsbsd_pkg: shared types and constants for the lsb stego stream decoder
// used by lsbsd_core and lsb_stego_stream_decoder_top; no dependencies
package lsbsd_pkg;

	localparam int MAX_MAGIC     = 8;
	localparam int MAGIC_W       = 8 * MAX_MAGIC;
	localparam int MAGIC_SEL_W   = 3;
	localparam int CFG_INDEX_W   = 2;

	localparam logic [7:0]  HEADER_SKIP_RST = 8'd54;
	localparam logic [3:0]  MAGIC_LEN_RST   = 4'd2;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_HEADER_SKIP = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAGIC_LEN   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MAGIC_BYTES = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_EXT    = 2'd0;
	localparam logic [1:0] KIND_DATA   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic       magic_bad;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [7:0]         header_skip;
		logic [3:0]         magic_len;
		logic [MAGIC_W-1:0] magic_bytes;
	} cfg_t;

endpackage

/* hdl/lsbsd_core.sv */
// lsbsd_core: frame parser state and per-byte decode logic
// depends on lsbsd_pkg; one image byte is taken per accepted request
module lsbsd_core import lsbsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_take,
	input  logic [7:0] image_byte,
	input  logic       restart,
	input  cfg_t       cfg,
	output logic       res_valid,
	output result_t    res
);

	localparam logic [3:0] PH_SKIP  = 4'd0;
	localparam logic [3:0] PH_MLEN  = 4'd1;
	localparam logic [3:0] PH_MAGIC = 4'd2;
	localparam logic [3:0] PH_ELEN  = 4'd3;
	localparam logic [3:0] PH_EXT   = 4'd4;
	localparam logic [3:0] PH_FSIZE = 4'd5;
	localparam logic [3:0] PH_DATA  = 4'd6;
	localparam logic [3:0] PH_DONE  = 4'd7;
	localparam logic [3:0] PH_FAIL  = 4'd8;

	logic [3:0]  phase_q, phase_n, ph, wp;
	logic [7:0]  hcount_q, hcount_n, hc;
	logic [4:0]  bcount_q, bcount_n, bc;
	logic [31:0] shift_q, shift_n, sw;
	logic [31:0] remain_q, remain_n, rem;
	logic [3:0]  mindex_q, mindex_n, mi;
	logic        mismatch_q, mismatch_n, mm;
	logic        active, done, word_ph, res_v;
	logic [3:0]  want;
	logic [7:0]  ch, expect_ch;
	result_t     res_n;

	always_comb begin
		// restart clears the frame before this byte is looked at
		ph  = restart ? PH_SKIP : phase_q;
		hc  = restart ? 8'd0 : hcount_q;
		bc  = restart ? 5'd0 : bcount_q;
		sw  = restart ? 32'd0 : shift_q;
		rem = restart ? 32'd0 : remain_q;
		mi  = restart ? 4'd0 : mindex_q;
		mm  = restart ? 1'b0 : mismatch_q;

		phase_n    = ph;
		hcount_n   = hc;
		bcount_n   = bc;
		shift_n    = sw;
		remain_n   = rem;
		mindex_n   = mi;
		mismatch_n = mm;
		res_v      = 1'b0;
		res_n      = '0;
		active     = 1'b0;
		wp         = ph;
		done       = 1'b0;
		word_ph    = 1'b0;
		want       = (cfg.magic_len > 4'(MAX_MAGIC)) ? 4'(MAX_MAGIC) : cfg.magic_len;
		expect_ch  = cfg.magic_bytes[{mi[MAGIC_SEL_W-1:0], 3'b000} +: 8];

		if (ph == PH_SKIP) begin
			if (hc < cfg.header_skip) begin
				hcount_n = hc + 8'd1;
				if ((hc + 8'd1) >= cfg.header_skip)
					phase_n = PH_MLEN;
			end else begin
				wp      = PH_MLEN;
				phase_n = PH_MLEN;
				active  = 1'b1;
			end
		end else if (ph != PH_DONE && ph < PH_FAIL) begin
			active = 1'b1;
		end

		shift_n = active ? {sw[30:0], image_byte[0]} : sw;
		ch      = shift_n[7:0];

		if (active) begin
			word_ph  = (wp == PH_MLEN) || (wp == PH_ELEN) || (wp == PH_FSIZE);
			done     = word_ph ? (bc >= 5'd31) : (bc >= 5'd7);
			bcount_n = done ? 5'd0 : bc + 5'd1;
		end

		if (done) begin
			unique case (wp)
				PH_MLEN: begin
					remain_n = shift_n;
					mindex_n = 4'd0;
					if (shift_n > {28'd0, want}) begin
						mismatch_n      = 1'b1;
						res_v           = 1'b1;
						res_n.kind      = KIND_STATUS;
						res_n.magic_bad = 1'b1;
						phase_n         = PH_FAIL;
					end else begin
						mismatch_n = (shift_n < {28'd0, want});
						if (shift_n == 32'd0) begin
							res_v           = 1'b1;
							res_n.kind      = KIND_STATUS;
							res_n.magic_bad = mismatch_n;
							phase_n         = mismatch_n ? PH_FAIL : PH_ELEN;
						end else begin
							phase_n = PH_MAGIC;
						end
					end
				end
				PH_MAGIC: begin
					mismatch_n = mm | (ch != expect_ch);
					mindex_n   = mi + 4'd1;
					remain_n   = rem - 32'd1;
					if (remain_n == 32'd0) begin
						res_v           = 1'b1;
						res_n.kind      = KIND_STATUS;
						res_n.magic_bad = mismatch_n;
						phase_n         = mismatch_n ? PH_FAIL : PH_ELEN;
					end
				end
				PH_ELEN: begin
					remain_n = shift_n;
					phase_n  = (shift_n == 32'd0) ? PH_FSIZE : PH_EXT;
				end
				PH_EXT: begin
					res_v          = 1'b1;
					res_n.out_byte = ch;
					res_n.kind     = KIND_EXT;
					remain_n       = rem - 32'd1;
					if (remain_n == 32'd0)
						phase_n = PH_FSIZE;
				end
				PH_FSIZE: begin
					remain_n = shift_n;
					phase_n  = (shift_n == 32'd0) ? PH_DONE : PH_DATA;
				end
				PH_DATA: begin
					res_v          = 1'b1;
					res_n.out_byte = ch;
					res_n.kind     = KIND_DATA;
					res_n.last     = (rem == 32'd1);
					remain_n       = rem - 32'd1;
					if (remain_n == 32'd0)
						phase_n = PH_DONE;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SKIP;
			hcount_q   <= '0;
			bcount_q   <= '0;
			shift_q    <= '0;
			remain_q   <= '0;
			mindex_q   <= '0;
			mismatch_q <= 1'b0;
		end else if (in_take) begin
			phase_q    <= phase_n;
			hcount_q   <= hcount_n;
			bcount_q   <= bcount_n;
			shift_q    <= shift_n;
			remain_q   <= remain_n;
			mindex_q   <= mindex_n;
			mismatch_q <= mismatch_n;
		end
	end

	assign res_valid = in_take & res_v;
	assign res       = res_n;

endmodule

/* hdl/lsb_stego_stream_decoder_top.sv */
// lsb_stego_stream_decoder_top: stream ports, config registers, result register
// depends on lsbsd_pkg and lsbsd_core
// result: m_tvalid rises in the cycle after the image byte request that made it is taken
// throughput: one image byte per cycle; s_tready drops only while a held result
// is not taken, the result register being the one stage between the two sides
// reset: arst_n clears frame state to the header skip phase and loads register
// defaults (header_skip 54, magic_len 2, magic_bytes 0); no clearing pass
module lsb_stego_stream_decoder_top import lsbsd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,   // image_byte[7:0]
	input  logic [0:0]             s_tuser,   // restart
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [7:0]             m_tdata,   // out_byte[7:0]
	output logic [2:0]             m_tuser,   // magic_bad, kind[1:0]
	output logic                   m_tlast,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [MAGIC_W-1:0]     cfg_data
);

	cfg_t    cfg_q;
	logic    take;
	logic    res_valid;
	result_t res;
	logic    out_valid_q;
	result_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_skip <= HEADER_SKIP_RST;
			cfg_q.magic_len   <= MAGIC_LEN_RST;
			cfg_q.magic_bytes <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HEADER_SKIP: cfg_q.header_skip <= cfg_data[7:0];
				REG_MAGIC_LEN:   cfg_q.magic_len   <= cfg_data[3:0];
				REG_MAGIC_BYTES: cfg_q.magic_bytes <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign s_tready = !out_valid_q || m_tready;
	assign take     = s_tvalid && s_tready;

	lsbsd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_take    (take),
		.image_byte (s_tdata),
		.restart    (s_tuser[0]),
		.cfg        (cfg_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.out_byte;
	assign m_tuser  = {out_q.magic_bad, out_q.kind};
	assign m_tlast  = out_q.last;

`ifndef NO_ASSERTIONS
	a_last_on_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[1:0] == KIND_DATA)
		else $error("last mark on a result that is not a data byte");

	a_bad_on_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tuser[1:0] == KIND_STATUS && m_tdata == 8'd0)
		else $error("magic_bad set on a character result");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while result register is empty");

	a_result_loads: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> m_tvalid)
		else $error("decoded result did not reach the result register");
`endif

endmodule
